// ----- hdl/jpeg2000_codeblock_geometry_macros.svh -----
// ---------------------------------------------------------------------------
// jpeg2000_codeblock_geometry assertion macros
// shared property forms for the geometry block checks
// ---------------------------------------------------------------------------
`ifndef JPEG2000_CODEBLOCK_GEOMETRY_MACROS_SVH
`define JPEG2000_CODEBLOCK_GEOMETRY_MACROS_SVH

// same-cycle implication, disabled in reset
`define CBG_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define CBG_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/cbg_pkg.sv -----
// ---------------------------------------------------------------------------
// cbg_pkg
// shared constants, types and helpers of the code-block geometry block
// ---------------------------------------------------------------------------
package cbg_pkg;

  localparam int COORD_BITS = 16;
  localparam int SETTLE     = 19;
  localparam int SETTLE_W   = $clog2(SETTLE + 1);

  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd0;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd1;
  localparam logic [2:0] CFG_TILE_WIDTH   = 3'd2;
  localparam logic [2:0] CFG_TILE_HEIGHT  = 3'd3;
  localparam logic [2:0] CFG_DECOMP       = 3'd4;
  localparam logic [2:0] CFG_CBLK_W_EXP   = 3'd5;
  localparam logic [2:0] CFG_CBLK_H_EXP   = 3'd6;

  typedef struct packed {
    logic [3:0]  res;
    logic [1:0]  orient;
    logic [27:0] cblk;
    logic        ok;
  } req_side_t;

  typedef struct packed {
    logic [1:0]  orient;
    logic [17:0] left;
    logic [17:0] top;
    logic [16:0] wide;
    logic [16:0] tall;
    logic [15:0] across;
    logic [15:0] down;
    logic        ok;
  } band_side_t;

  function automatic logic [3:0] clamp_exp(input logic [3:0] e);
    if (e < 4'd2) begin
      return 4'd2;
    end else if (e > 4'd10) begin
      return 4'd10;
    end
    return e;
  endfunction

  function automatic logic [15:0] sat_coord(input logic [17:0] v);
    if (v > 18'((1 << COORD_BITS) - 1)) begin
      return 16'((1 << COORD_BITS) - 1);
    end
    return v[15:0];
  endfunction

endpackage

// ----- hdl/jpeg2000_codeblock_geometry.sv -----
// ---------------------------------------------------------------------------
// jpeg2000_codeblock_geometry
// tile / subband / code-block geometry; while no stall holds it, one request per cycle
// ---------------------------------------------------------------------------
// usage
//   request channel: req_valid / req_stall carries tile_index, res_level,
//   band_index and cblk_index; a beat moves when valid is high and stall low
//   result channel: res_valid / res_stall carries the band and code-block
//   geometry and request_ok; a rejected request gives all zero fields
//   configuration: cfg_write with cfg_index and cfg_data, only while idle
// pipeline and throughput
//   one beat per cycle while neither channel stalls; the pipeline is made of
//   two bit-serial divider pipelines (32 stages for the tile index split,
//   28 for the code-block index split) plus 7 stages
// reset and configuration
//   after reset and after every register write the tile counts are rebuilt
//   by a 17-stage divider; req_stall stays high meanwhile
// stall
//   the whole pipeline moves together; while res_stall holds a result the
//   pipeline freezes and req_stall is raised, nothing is lost or repeated
// ---------------------------------------------------------------------------
`include "jpeg2000_codeblock_geometry_macros.svh"

module jpeg2000_codeblock_geometry (
  input  logic        clk,
  input  logic        rst,
  // configuration
  input  logic        cfg_write,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  // request channel
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [31:0] tile_index,
  input  logic [3:0]  res_level,
  input  logic [1:0]  band_index,
  input  logic [27:0] cblk_index,
  // result channel
  output logic        res_valid,
  input  logic        res_stall,
  output logic [1:0]  band_orient,
  output logic [15:0] band_left,
  output logic [15:0] band_top,
  output logic [15:0] band_wide,
  output logic [15:0] band_tall,
  output logic [15:0] blocks_across,
  output logic [15:0] blocks_down,
  output logic [15:0] block_left,
  output logic [15:0] block_top,
  output logic [10:0] block_wide,
  output logic [10:0] block_tall,
  output logic        request_ok
);
  import cbg_pkg::*;

  // configuration registers
  logic [15:0] img_w, img_h, tile_w, tile_h;
  logic [3:0]  levels, cbw_exp, cbh_exp;
  logic [SETTLE_W-1:0] settle;

  always_ff @(posedge clk) begin
    if (rst) begin
      img_w   <= 16'd512;
      img_h   <= 16'd512;
      tile_w  <= 16'd0;
      tile_h  <= 16'd0;
      levels  <= 4'd5;
      cbw_exp <= 4'd6;
      cbh_exp <= 4'd6;
      settle  <= SETTLE_W'(SETTLE);
    end else begin
      if (cfg_write) begin
        settle <= SETTLE_W'(SETTLE);
        case (cfg_index)
          CFG_IMAGE_WIDTH:  img_w   <= cfg_data;
          CFG_IMAGE_HEIGHT: img_h   <= cfg_data;
          CFG_TILE_WIDTH:   tile_w  <= cfg_data;
          CFG_TILE_HEIGHT:  tile_h  <= cfg_data;
          CFG_DECOMP:       levels  <= cfg_data[3:0];
          CFG_CBLK_W_EXP:   cbw_exp <= cfg_data[3:0];
          CFG_CBLK_H_EXP:   cbh_exp <= cfg_data[3:0];
          default: ;
        endcase
      end else if (settle != '0) begin
        settle <= settle - 1'b1;
      end
    end
  end

  // effective tile size, zero or oversize means the whole image
  logic [15:0] tw, th;
  assign tw = (tile_w == 16'd0 || tile_w > img_w) ? img_w : tile_w;
  assign th = (tile_h == 16'd0 || tile_h > img_h) ? img_h : tile_h;

  // tile grid counts, rebuilt continuously from the registers
  logic [16:0] nx_q, ny_q;
  logic [15:0] nx, ny;

  cbg_div #(.NUM_W(17), .DEN_W(16), .SIDE_W(1)) u_nx_div (
    .clk(clk), .rst(rst), .en(1'b1), .in_valid(1'b1),
    .num({1'b0, img_w} + {1'b0, tw} - 17'd1), .den(tw), .side_in(1'b0),
    .out_valid(), .quo(nx_q), .rem(), .side_out()
  );

  cbg_div #(.NUM_W(17), .DEN_W(16), .SIDE_W(1)) u_ny_div (
    .clk(clk), .rst(rst), .en(1'b1), .in_valid(1'b1),
    .num({1'b0, img_h} + {1'b0, th} - 17'd1), .den(th), .side_in(1'b0),
    .out_valid(), .quo(ny_q), .rem(), .side_out()
  );

  assign nx = nx_q[15:0];
  assign ny = ny_q[15:0];

  // pipeline moves as a whole whenever the output register can take a beat
  logic adv;
  assign adv       = !res_valid || !res_stall;
  assign req_stall = !adv || (settle != '0);

  // stage a: range checks on the request
  logic        a_valid;
  req_side_t   a_side;
  logic [31:0] a_tile;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= req_valid && !req_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_tile        <= tile_index;
      a_side.res    <= res_level;
      a_side.orient <= (res_level == 4'd0) ? 2'd0 : band_index + 2'd1;
      a_side.cblk   <= cblk_index;
      a_side.ok     <= img_w != 16'd0 && img_h != 16'd0 && res_level <= levels &&
                       ((res_level == 4'd0) ? (band_index == 2'd0) : (band_index != 2'd3));
    end
  end

  // tile index split into column and row
  logic        t_valid;
  logic [31:0] t_row;
  logic [15:0] t_col;
  req_side_t   t_side;

  cbg_div #(.NUM_W(32), .DEN_W(16), .SIDE_W($bits(req_side_t))) u_tile_div (
    .clk(clk), .rst(rst), .en(adv), .in_valid(a_valid),
    .num(a_tile), .den(nx), .side_in(a_side),
    .out_valid(t_valid), .quo(t_row), .rem(t_col), .side_out(t_side)
  );

  // stage b: tile bounds
  logic        b_valid;
  req_side_t   b_side;
  logic [15:0] b_x0, b_y0, b_x1, b_y1;
  logic [31:0] x0_full, y0_full;
  logic [16:0] x1_sum, y1_sum;

  assign x0_full = t_col * tw;
  assign y0_full = t_row[15:0] * th;
  assign x1_sum  = {1'b0, x0_full[15:0]} + {1'b0, tw};
  assign y1_sum  = {1'b0, y0_full[15:0]} + {1'b0, th};

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= t_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_side.res    <= t_side.res;
      b_side.orient <= t_side.orient;
      b_side.cblk   <= t_side.cblk;
      b_side.ok     <= t_side.ok && (t_row < {16'd0, ny});
      b_x0          <= x0_full[15:0];
      b_y0          <= y0_full[15:0];
      b_x1          <= (x1_sum > {1'b0, img_w}) ? img_w : x1_sum[15:0];
      b_y1          <= (y1_sum > {1'b0, img_h}) ? img_h : y1_sum[15:0];
    end
  end

  // stage c: subband bounds at the decomposition level of this resolution
  logic [4:0]  dec_w;
  logic [3:0]  dec;
  logic [16:0] div_m1, half, hx, hy;

  assign dec_w  = (b_side.res == 4'd0) ? {1'b0, levels}
                                       : {1'b0, levels} - {1'b0, b_side.res} + 5'd1;
  assign dec    = dec_w[3:0];
  assign div_m1 = (17'd1 << dec) - 17'd1;
  assign half   = (dec == 4'd0) ? 17'd0 : (17'd1 << (dec - 4'd1));
  assign hx     = b_side.orient[0] ? half : 17'd0;
  assign hy     = b_side.orient[1] ? half : 17'd0;

  logic        c_valid;
  req_side_t   c_side;
  logic [16:0] c_sx0, c_sy0, c_sx1, c_sy1, c_llw, c_llh;

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_side <= b_side;
      c_sx0  <= ({1'b0, b_x0} + div_m1 - hx) >> dec;
      c_sy0  <= ({1'b0, b_y0} + div_m1 - hy) >> dec;
      c_sx1  <= ({1'b0, b_x1} + div_m1 - hx) >> dec;
      c_sy1  <= ({1'b0, b_y1} + div_m1 - hy) >> dec;
      c_llw  <= ({1'b0, b_x1} - {1'b0, b_x0} + div_m1) >> dec;
      c_llh  <= ({1'b0, b_y1} - {1'b0, b_y0} + div_m1) >> dec;
    end
  end

  // stage d: band size and position with the ll offset
  logic        d_valid;
  req_side_t   d_side;
  logic [16:0] d_bw, d_bh;
  logic [17:0] d_left, d_top;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_side <= c_side;
      d_bw   <= c_sx1 - c_sx0;
      d_bh   <= c_sy1 - c_sy0;
      d_left <= {1'b0, c_sx0} + (c_side.orient[0] ? {1'b0, c_llw} : 18'd0);
      d_top  <= {1'b0, c_sy0} + (c_side.orient[1] ? {1'b0, c_llh} : 18'd0);
    end
  end

  // stage e: code-block grid of the band
  logic [3:0]  ew, eh;
  logic [17:0] nxb_sum, nyb_sum, nxb_full, nyb_full;

  assign ew       = clamp_exp(cbw_exp);
  assign eh       = clamp_exp(cbh_exp);
  assign nxb_sum  = {1'b0, d_bw} + ((18'd1 << ew) - 18'd1);
  assign nyb_sum  = {1'b0, d_bh} + ((18'd1 << eh) - 18'd1);
  assign nxb_full = nxb_sum >> ew;
  assign nyb_full = nyb_sum >> eh;

  logic        e_valid;
  logic [27:0] e_cblk;
  band_side_t  e_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_cblk        <= d_side.cblk;
      e_side.orient <= d_side.orient;
      e_side.left   <= d_left;
      e_side.top    <= d_top;
      e_side.wide   <= d_bw;
      e_side.tall   <= d_bh;
      e_side.across <= nxb_full[15:0];
      e_side.down   <= nyb_full[15:0];
      e_side.ok     <= d_side.ok && nxb_full != 18'd0 && nyb_full != 18'd0;
    end
  end

  // code-block index split into column and row
  logic        k_valid;
  logic [27:0] k_row;
  logic [15:0] k_col;
  band_side_t  k_side;

  cbg_div #(.NUM_W(28), .DEN_W(16), .SIDE_W($bits(band_side_t))) u_cblk_div (
    .clk(clk), .rst(rst), .en(adv), .in_valid(e_valid),
    .num(e_cblk), .den(e_side.across), .side_in(e_side),
    .out_valid(k_valid), .quo(k_row), .rem(k_col), .side_out(k_side)
  );

  // stage f: code-block origin and clipped far corner
  logic [26:0] bx0_full, by0_full;
  logic [17:0] bx1_sum, by1_sum;

  assign bx0_full = {11'd0, k_col} << ew;
  assign by0_full = {11'd0, k_row[15:0]} << eh;
  assign bx1_sum  = {1'b0, bx0_full[16:0]} + (18'd1 << ew);
  assign by1_sum  = {1'b0, by0_full[16:0]} + (18'd1 << eh);

  logic        f_valid;
  band_side_t  f_side;
  logic [16:0] f_bx0, f_by0, f_bx1, f_by1;

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= k_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f_side.orient <= k_side.orient;
      f_side.left   <= k_side.left;
      f_side.top    <= k_side.top;
      f_side.wide   <= k_side.wide;
      f_side.tall   <= k_side.tall;
      f_side.across <= k_side.across;
      f_side.down   <= k_side.down;
      f_side.ok     <= k_side.ok && (k_row < {12'd0, k_side.down});
      f_bx0         <= bx0_full[16:0];
      f_by0         <= by0_full[16:0];
      f_bx1         <= (bx1_sum > {1'b0, k_side.wide}) ? k_side.wide : bx1_sum[16:0];
      f_by1         <= (by1_sum > {1'b0, k_side.tall}) ? k_side.tall : by1_sum[16:0];
    end
  end

  // stage g: output register, saturation and zeroing of rejected requests
  logic [16:0] cw_diff, ch_diff;
  logic        ok;

  assign cw_diff = f_bx1 - f_bx0;
  assign ch_diff = f_by1 - f_by0;
  assign ok      = f_side.ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      request_ok    <= ok;
      band_orient   <= ok ? f_side.orient : 2'd0;
      band_left     <= ok ? sat_coord(f_side.left) : 16'd0;
      band_top      <= ok ? sat_coord(f_side.top) : 16'd0;
      band_wide     <= ok ? sat_coord({1'b0, f_side.wide}) : 16'd0;
      band_tall     <= ok ? sat_coord({1'b0, f_side.tall}) : 16'd0;
      blocks_across <= ok ? f_side.across : 16'd0;
      blocks_down   <= ok ? f_side.down : 16'd0;
      block_left    <= ok ? sat_coord({1'b0, f_bx0}) : 16'd0;
      block_top     <= ok ? sat_coord({1'b0, f_by0}) : 16'd0;
      block_wide    <= ok ? cw_diff[10:0] : 11'd0;
      block_tall    <= ok ? ch_diff[10:0] : 11'd0;
    end
  end

  // checks
  `CBG_ASSERT_SAME(a_rejected_zero, res_valid && !request_ok, band_wide == 16'd0 && blocks_across == 16'd0 && block_wide == 11'd0, "rejected beat carries geometry")
  `CBG_ASSERT_SAME(a_block_nonempty, res_valid && request_ok, block_wide != 11'd0 && block_tall != 11'd0 && block_wide <= 11'd1024, "accepted beat has empty or oversize block")
  `CBG_ASSERT_NEXT(a_cfg_settles, cfg_write, req_stall, "request taken while tile counts rebuild")
  `CBG_ASSERT_NEXT(a_freeze, res_valid && res_stall, res_valid && $stable(band_left) && $stable(block_top), "result changed under stall")

endmodule

// ----- hdl/cbg_div.sv -----
// ---------------------------------------------------------------------------
// cbg_div
// pipelined restoring divider, one quotient bit per stage, with sideband
// ---------------------------------------------------------------------------
module cbg_div #(
  parameter int NUM_W  = 32,
  parameter int DEN_W  = 16,
  parameter int SIDE_W = 1
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  logic [NUM_W-1:0]  num,
  input  logic [DEN_W-1:0]  den,
  input  logic [SIDE_W-1:0] side_in,
  output logic              out_valid,
  output logic [NUM_W-1:0]  quo,
  output logic [DEN_W-1:0]  rem,
  output logic [SIDE_W-1:0] side_out
);

  logic              v [NUM_W];
  logic [NUM_W-1:0]  w [NUM_W];
  logic [DEN_W-1:0]  r [NUM_W];
  logic [DEN_W-1:0]  d [NUM_W];
  logic [SIDE_W-1:0] s [NUM_W];

  for (genvar i = 0; i < NUM_W; i++) begin : g_stage
    logic              v_in;
    logic [NUM_W-1:0]  w_in;
    logic [DEN_W-1:0]  r_in;
    logic [DEN_W-1:0]  d_in;
    logic [SIDE_W-1:0] s_in;
    logic [DEN_W:0]    trial;
    logic [DEN_W:0]    diff;
    logic              fit;

    if (i == 0) begin : g_first
      assign v_in = in_valid;
      assign w_in = num;
      assign r_in = '0;
      assign d_in = den;
      assign s_in = side_in;
    end else begin : g_next
      assign v_in = v[i-1];
      assign w_in = w[i-1];
      assign r_in = r[i-1];
      assign d_in = d[i-1];
      assign s_in = s[i-1];
    end

    assign trial = {r_in, w_in[NUM_W-1]};
    assign diff  = trial - {1'b0, d_in};
    assign fit   = trial >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (en) begin
        v[i] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        w[i] <= {w_in[NUM_W-2:0], fit};
        r[i] <= fit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        d[i] <= d_in;
        s[i] <= s_in;
      end
    end
  end

  assign out_valid = v[NUM_W-1];
  assign quo       = w[NUM_W-1];
  assign rem       = r[NUM_W-1];
  assign side_out  = s[NUM_W-1];

endmodule

// ----- dv/tb_jpeg2000_codeblock_geometry.sv -----
// ---------------------------------------------------------------------------
// tb_jpeg2000_codeblock_geometry
// self-checking bench for the tile / subband / code-block geometry block
// ---------------------------------------------------------------------------
// requests are queued by the stimulus process and sent by a clocked driver
// with random gaps. A clocked monitor stalls at random and holds off once for
// a long stretch. Every accepted request is run through a local geometry
// predictor, and each result beat is checked against the oldest prediction.
// The configuration moves through several settings, extremes included, and
// is written only while the block is idle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_jpeg2000_codeblock_geometry;
  import cbg_pkg::*;

  // one request beat
  typedef struct packed {
    logic [31:0] tile;
    logic [3:0]  res;
    logic [1:0]  band;
    logic [27:0] cblk;
  } geom_req_t;

  // one result beat, in port order
  typedef struct packed {
    logic [1:0]  orient;
    logic [15:0] left;
    logic [15:0] top;
    logic [15:0] wide;
    logic [15:0] tall;
    logic [15:0] across;
    logic [15:0] down;
    logic [15:0] blk_left;
    logic [15:0] blk_top;
    logic [10:0] blk_wide;
    logic [10:0] blk_tall;
    logic        ok;
  } geom_t;

  logic        clk;
  logic        rst;
  logic        cfg_write;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_data;
  logic        req_valid;
  logic        req_stall;
  logic [31:0] tile_index;
  logic [3:0]  res_level;
  logic [1:0]  band_index;
  logic [27:0] cblk_index;
  logic        res_valid;
  logic        res_stall;
  logic [1:0]  band_orient;
  logic [15:0] band_left;
  logic [15:0] band_top;
  logic [15:0] band_wide;
  logic [15:0] band_tall;
  logic [15:0] blocks_across;
  logic [15:0] blocks_down;
  logic [15:0] block_left;
  logic [15:0] block_top;
  logic [10:0] block_wide;
  logic [10:0] block_tall;
  logic        request_ok;

  jpeg2000_codeblock_geometry i_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_valid     (req_valid),
    .req_stall     (req_stall),
    .tile_index    (tile_index),
    .res_level     (res_level),
    .band_index    (band_index),
    .cblk_index    (cblk_index),
    .res_valid     (res_valid),
    .res_stall     (res_stall),
    .band_orient   (band_orient),
    .band_left     (band_left),
    .band_top      (band_top),
    .band_wide     (band_wide),
    .band_tall     (band_tall),
    .blocks_across (blocks_across),
    .blocks_down   (blocks_down),
    .block_left    (block_left),
    .block_top     (block_top),
    .block_wide    (block_wide),
    .block_tall    (block_tall),
    .request_ok    (request_ok)
  );

  // 8 ns clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mirror of the register file, reset values of the block
  bit [63:0] img_w = 512, img_h = 512, til_w = 0, til_h = 0;
  bit [63:0] levels = 5, exp_w = 6, exp_h = 6;

  geom_req_t req_pending[$];   // requests not yet offered
  geom_t     geom_due[$];      // predicted results not yet seen
  int        mismatches = 0;
  int        results_seen = 0;
  bit        gappy = 1'b1;     // sender idles between beats
  bit        choppy = 1'b1;    // receiver stalls between beats

  function automatic bit [63:0] exp_limit(bit [63:0] e);
    if (e < 2) begin
      return 2;
    end else if (e > 10) begin
      return 10;
    end
    return e;
  endfunction

  function automatic bit [15:0] coord_sat(bit [63:0] v);
    return (v > 64'hFFFF) ? 16'hFFFF : v[15:0];
  endfunction

  function automatic bit [63:0] min64(bit [63:0] a, bit [63:0] b);
    return (a < b) ? a : b;
  endfunction

  // geometry of one request under the mirrored registers
  function automatic geom_t geom_predict(bit [31:0] t_in, bit [3:0] r_in,
                                         bit [1:0] b_in, bit [27:0] k_in);
    geom_t g;
    bit [63:0] t, r, b, k, tw, th, nx, ny, p, q, tlx, tly, brx, bry;
    bit [63:0] dec, div, half, orient, xob, yob;
    bit [63:0] sx0, sy0, sx1, sy1, bw, bh, left, top;
    bit [63:0] ew, eh, cw, ch, nxb, nyb, ox, oy, cx0, cy0, cx1, cy1;
    g = '0;
    t = t_in;
    r = r_in;
    b = b_in;
    k = k_in;
    if (img_w == 0 || img_h == 0) return g;
    tw = (til_w == 0 || til_w > img_w) ? img_w : til_w;
    th = (til_h == 0 || til_h > img_h) ? img_h : til_h;
    nx = (img_w + tw - 1) / tw;
    ny = (img_h + th - 1) / th;
    if (t >= nx * ny) return g;
    if (r > levels) return g;
    if ((r == 0) ? (b != 0) : (b > 2)) return g;
    orient = (r == 0) ? 0 : b + 1;
    xob = orient & 1;
    yob = (orient >> 1) & 1;
    p = t % nx;
    q = t / nx;
    tlx = p * tw;
    tly = q * th;
    brx = min64((p + 1) * tw, img_w);
    bry = min64((q + 1) * th, img_h);
    // levels 0 and 1 share the deepest decomposition
    dec = (r == 0) ? levels : levels - (r - 1);
    div = 64'd1 << dec;
    half = (dec == 0) ? 0 : (64'd1 << (dec - 1));
    sx0 = (tlx + div - 1 - half * xob) >> dec;
    sy0 = (tly + div - 1 - half * yob) >> dec;
    sx1 = (brx + div - 1 - half * xob) >> dec;
    sy1 = (bry + div - 1 - half * yob) >> dec;
    bw = sx1 - sx0;
    bh = sy1 - sy0;
    // high-pass bands sit past the low-pass width / height
    left = sx0 + xob * ((brx - tlx + div - 1) >> dec);
    top = sy0 + yob * ((bry - tly + div - 1) >> dec);
    ew = exp_limit(exp_w);
    eh = exp_limit(exp_h);
    cw = 64'd1 << ew;
    ch = 64'd1 << eh;
    nxb = (bw + cw - 1) >> ew;
    nyb = (bh + ch - 1) >> eh;
    // also catches the empty band
    if (k >= nxb * nyb) return g;
    ox = k % nxb;
    oy = k / nxb;
    cx0 = ox * cw;
    cy0 = oy * ch;
    cx1 = min64((ox + 1) * cw, bw);
    cy1 = min64((oy + 1) * ch, bh);
    g.orient = orient[1:0];
    g.left = coord_sat(left);
    g.top = coord_sat(top);
    g.wide = coord_sat(bw);
    g.tall = coord_sat(bh);
    g.across = coord_sat(nxb);
    g.down = coord_sat(nyb);
    g.blk_left = coord_sat(cx0);
    g.blk_top = coord_sat(cy0);
    g.blk_wide = 11'(cx1 - cx0);
    g.blk_tall = 11'(cy1 - cy0);
    g.ok = 1'b1;
    return g;
  endfunction

  // ---------------------------------------------------------------------
  // request driver: changes at the falling edge, holds while stalled
  // ---------------------------------------------------------------------
  bit req_fired = 1'b0;
  int req_gap = 0;

  always @(posedge clk) begin
    req_fired <= req_valid && !req_stall;
    if (!rst && req_valid && !req_stall) begin
      geom_due.push_back(geom_predict(tile_index, res_level, band_index, cblk_index));
    end
  end

  always @(negedge clk) begin
    geom_req_t nxt;
    logic      v;
    v = req_valid;
    if (rst) begin
      v = 1'b0;
    end else if (!req_valid || req_fired) begin
      // previous beat gone (or none): idle out the gap, then offer the next
      v = 1'b0;
      if (req_gap > 0) begin
        req_gap--;
      end else if (req_pending.size() > 0) begin
        nxt = req_pending.pop_front();
        tile_index <= nxt.tile;
        res_level <= nxt.res;
        band_index <= nxt.band;
        cblk_index <= nxt.cblk;
        v = 1'b1;
        req_gap = (gappy && $urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
      end
    end
    req_valid <= v;
  end

  // ---------------------------------------------------------------------
  // result monitor: random stalls, one long hold-off, checks each beat
  // ---------------------------------------------------------------------
  bit res_fired = 1'b0;
  int res_wait = 0;
  int long_hold = 0;
  bit long_done = 1'b0;

  always @(posedge clk) begin
    geom_t got, want;
    res_fired <= res_valid && !res_stall;
    if (!rst && res_valid && !res_stall) begin
      got = '{band_orient, band_left, band_top, band_wide, band_tall, blocks_across,
              blocks_down, block_left, block_top, block_wide, block_tall, request_ok};
      results_seen++;
      if (geom_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = geom_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("result %0d mismatch", results_seen);
            $display("  expected %p", want);
            $display("  actual   %p", got);
          end
        end
      end
    end
  end

  // long hold-off, counted in cycles, long enough to fill the block
  always @(posedge clk) begin
    if (!rst && !long_done && results_seen >= 150) begin
      long_done = 1'b1;
      long_hold = 400;
    end else if (long_hold > 0) begin
      long_hold--;
    end
  end

  always @(negedge clk) begin
    logic s;
    s = 1'b0;
    if (res_fired) begin
      res_wait = (choppy && $urandom_range(0, 2) == 0) ? $urandom_range(0, 18) : 0;
    end
    if (rst) begin
      s = 1'b0;
    end else if (long_hold > 0) begin
      s = 1'b1;
    end else if (res_wait > 0) begin
      res_wait--;
      s = 1'b1;
    end
    res_stall <= s;
  end

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  task automatic reg_write(logic [2:0] idx, bit [15:0] val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_IMAGE_WIDTH:  img_w = val;
      CFG_IMAGE_HEIGHT: img_h = val;
      CFG_TILE_WIDTH:   til_w = val;
      CFG_TILE_HEIGHT:  til_h = val;
      CFG_DECOMP:       levels = val[3:0];
      CFG_CBLK_W_EXP:   exp_w = val[3:0];
      CFG_CBLK_H_EXP:   exp_h = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic setup(bit [15:0] iw, bit [15:0] ih, bit [15:0] tw, bit [15:0] th,
                       bit [3:0] dl, bit [3:0] ew, bit [3:0] eh);
    reg_write(CFG_IMAGE_WIDTH, iw);
    reg_write(CFG_IMAGE_HEIGHT, ih);
    reg_write(CFG_TILE_WIDTH, tw);
    reg_write(CFG_TILE_HEIGHT, th);
    reg_write(CFG_DECOMP, {12'd0, dl});
    reg_write(CFG_CBLK_W_EXP, {12'd0, ew});
    reg_write(CFG_CBLK_H_EXP, {12'd0, eh});
  endtask

  task automatic push_req(bit [31:0] t, bit [3:0] r, bit [1:0] b, bit [27:0] k);
    req_pending.push_back('{t, r, b, k});
  endtask

  // mostly well-formed requests, some out of range, some pure noise
  task automatic push_random(int n);
    bit [63:0] tiles, tw, th, blocks;
    bit [31:0] t;
    bit [3:0]  r;
    bit [1:0]  b;
    bit [27:0] k;
    geom_t     g;
    tw = (til_w == 0 || til_w > img_w) ? img_w : til_w;
    th = (til_h == 0 || til_h > img_h) ? img_h : til_h;
    tiles = (img_w == 0 || img_h == 0) ? 1 :
            ((img_w + tw - 1) / tw) * ((img_h + th - 1) / th);
    repeat (n) begin
      if ($urandom_range(0, 9) == 0) begin
        push_req($urandom, 4'($urandom), 2'($urandom), 28'($urandom));
      end else begin
        t = (tiles > 64'hFFFF_FFFF) ? $urandom : $urandom_range(0, 32'(tiles - 1));
        r = $urandom_range(0, levels[3:0]);
        b = (r == 0) ? 2'd0 : 2'($urandom_range(0, 2));
        if ($urandom_range(0, 19) == 0) t = t + 32'(tiles);
        if ($urandom_range(0, 19) == 0) b = 2'd3;
        g = geom_predict(t, r, b, 28'd0);
        blocks = 64'(g.across) * 64'(g.down);
        if (blocks > 64'hFFF_FFFF) blocks = 64'hFFF_FFFF;
        k = (g.ok && blocks > 0) ? 28'($urandom_range(0, 32'(blocks - 1))) : 28'($urandom);
        if ($urandom_range(0, 15) == 0) k = k + 28'(blocks);
        push_req(t, r, b, k);
      end
    end
  endtask

  // drain everything, then give the block its latency before a write
  task automatic settle();
    while (req_pending.size() > 0 || geom_due.size() > 0 || req_valid) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = CFG_IMAGE_WIDTH;
    cfg_data = '0;
    req_valid = 1'b0;
    res_stall = 1'b0;
    tile_index = '0;
    res_level = '0;
    band_index = '0;
    cblk_index = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed, reset configuration: 512x512 single tile, 5 levels, 64x64
    push_req(32'd0, 4'd0, 2'd0, 28'd0);
    push_req(32'd0, 4'd0, 2'd0, 28'd0);
    push_req(32'd0, 4'd0, 2'd1, 28'd0);          // high band at level 0
    push_req(32'd0, 4'd1, 2'd3, 28'd0);          // band 3 never exists
    push_req(32'd0, 4'd1, 2'd0, 28'd0);
    push_req(32'd0, 4'd1, 2'd1, 28'd0);
    push_req(32'd0, 4'd1, 2'd2, 28'd0);
    push_req(32'd0, 4'd5, 2'd0, 28'd15);
    push_req(32'd0, 4'd5, 2'd1, 28'd5);
    push_req(32'd0, 4'd5, 2'd2, 28'd15);
    push_req(32'd0, 4'd5, 2'd2, 28'd16);         // one past the last block
    push_req(32'd0, 4'd6, 2'd0, 28'd0);          // level past decomposition
    push_req(32'd0, 4'd15, 2'd2, 28'd0);
    push_req(32'd1, 4'd0, 2'd0, 28'd0);          // tile past the grid
    push_req(32'hFFFF_FFFF, 4'd2, 2'd1, 28'd0);
    push_req(32'd0, 4'd3, 2'd2, 28'hFFF_FFFF);
    push_req(32'd0, 4'd4, 2'd1, 28'd63);
    push_req(32'd0, 4'd4, 2'd1, 28'd64);
    push_req(32'd0, 4'd2, 2'd0, 28'd3);
    settle();

    // each phase: a setting, then random requests
    setup(16'd512, 16'd512, 16'd0, 16'd0, 4'd5, 4'd6, 4'd6);
    push_random(90);
    settle();
    gappy = 1'b0;
    choppy = 1'b0;
    setup(16'd100, 16'd80, 16'd32, 16'd16, 4'd3, 4'd2, 4'd2);
    push_random(90);
    settle();
    gappy = 1'b1;
    setup(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 4'd15, 4'd10, 4'd10);
    push_random(70);
    settle();
    choppy = 1'b1;
    setup(16'd1, 16'd1, 16'd0, 16'd0, 4'd0, 4'd0, 4'd15);   // exponents clamped
    push_random(40);
    settle();
    setup(16'd1000, 16'd700, 16'd128, 16'd100, 4'd2, 4'd11, 4'd1);
    push_random(90);
    settle();
    setup(16'd0, 16'd50, 16'd4, 16'd4, 4'd1, 4'd3, 4'd3);   // zero image width
    push_random(30);
    settle();
    reg_write(CFG_IMAGE_WIDTH, 16'd50);
    reg_write(CFG_IMAGE_HEIGHT, 16'd0);                      // zero image height
    push_random(20);
    settle();
    setup(16'd300, 16'hFFFF, 16'd7, 16'd1, 4'd15, 4'd3, 4'd4);
    push_random(80);
    settle();
    setup(16'd9, 16'd9, 16'd20, 16'd3, 4'd4, 4'd2, 4'd3);    // tile wider than image
    push_random(50);
    settle();
    repeat (6) begin
      setup($urandom_range(1, 3000), $urandom_range(1, 3000), $urandom_range(0, 600),
            $urandom_range(0, 600), $urandom_range(0, 15), $urandom_range(0, 15),
            $urandom_range(0, 15));
      push_random(60);
      settle();
    end

    if (mismatches == 0 && geom_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/cbg_pkg.sv
hdl/cbg_div.sv
hdl/jpeg2000_codeblock_geometry.sv
dv/tb_jpeg2000_codeblock_geometry.sv
